### hw/rtl/rle_sprite_blit_decoder_unit_defines.svh
`ifndef RLE_SPRITE_BLIT_DECODER_UNIT_DEFINES_SVH
`define RLE_SPRITE_BLIT_DECODER_UNIT_DEFINES_SVH

// check sampled on clk_i, masked while reset is low
`define RSBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check sampled on clk_i, reset included
`define RSBD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/rsbd_pkg.sv
`default_nettype none

package rsbd_pkg;

  localparam int unsigned ADDRESS_BITS = 20;
  localparam int unsigned PixAddrW     = 20;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 11;

  typedef enum logic [CfgIdxW-1:0] {
    RegRleMode     = 3'd0,
    RegBlockWidth  = 3'd1,
    RegBlockHeight = 3'd2,
    RegScreenWidth = 3'd3,
    RegPosX        = 3'd4,
    RegPosY        = 3'd5
  } rsbd_reg_e;

  typedef enum logic [3:0] {
    PhTag   = 4'b0001,
    PhSkip  = 4'b0010,
    PhCount = 4'b0100,
    PhLit   = 4'b1000
  } rsbd_phase_e;

  typedef struct packed {
    logic        rle_mode;
    logic [7:0]  block_width;
    logic [7:0]  block_height;
    logic [10:0] screen_width;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
  } rsbd_cfg_t;

  typedef struct packed {
    logic                emit;
    logic [PixAddrW-1:0] addr;
    logic [7:0]          value;
  } rsbd_res_t;

endpackage

`default_nettype wire

### hw/rtl/rsbd_addr.sv
`default_nettype none

module rsbd_addr import rsbd_pkg::*; (
  input  rsbd_cfg_t           cfg_i,
  input  logic [9:0]          col_i,
  input  logic [7:0]          row_i,
  output logic [PixAddrW-1:0] addr_o
);

  localparam int unsigned SumW = 23;
  localparam logic [SumW-1:0] AddrMask = SumW'((64'd1 << ADDRESS_BITS) - 64'd1);

  logic [10:0]     y_sum;
  logic [21:0]     y_off;
  logic [SumW-1:0] sum;

  assign y_sum  = 11'(cfg_i.pos_y) + 11'(row_i);
  assign y_off  = 22'(cfg_i.screen_width) * 22'(y_sum);
  assign sum    = SumW'(cfg_i.pos_x) + SumW'(col_i) + SumW'(y_off);
  assign addr_o = PixAddrW'(sum & AddrMask);

endmodule

`default_nettype wire

### hw/rtl/rsbd_cfg.sv
`default_nettype none

module rsbd_cfg import rsbd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] data_i,
  output rsbd_cfg_t           cfg_o
);

  rsbd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      case (idx_i)
        RegRleMode:     cfg_d.rle_mode     = data_i[0];
        RegBlockWidth:  cfg_d.block_width  = data_i[7:0];
        RegBlockHeight: cfg_d.block_height = data_i[7:0];
        RegScreenWidth: cfg_d.screen_width = data_i[10:0];
        RegPosX:        cfg_d.pos_x        = data_i[9:0];
        RegPosY:        cfg_d.pos_y        = data_i[9:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rle_mode     <= 1'b1;
      cfg_q.block_width  <= 8'd16;
      cfg_q.block_height <= 8'd16;
      cfg_q.screen_width <= 11'd320;
      cfg_q.pos_x        <= 10'd0;
      cfg_q.pos_y        <= 10'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/rsbd_core.sv
`default_nettype none

module rsbd_core import rsbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rsbd_cfg_t  cfg_i,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       restart_i,
  output rsbd_res_t  res_o
);

  typedef struct packed {
    logic [9:0] col;
    logic [7:0] row;
    logic       fin;
  } pos_t;

  function automatic pos_t row_end(pos_t p, logic [7:0] bw, logic [7:0] bh);
    pos_t r;
    r = p;
    if (r.col >= 10'(bw)) begin
      r.col = '0;
      r.row = r.row + 8'd1;
      if (r.row >= bh || r.row == 8'd0) r.fin = 1'b1;
    end
    if (r.row >= bh) r.fin = 1'b1;
    return r;
  endfunction

  rsbd_phase_e phase_q, phase_d;
  logic [7:0]  lit_q, lit_d;
  pos_t        pos_q, pos_d;
  logic [15:0] cons_q, cons_d;

  logic [15:0] total;
  logic        emit;
  logic [9:0]  e_col;
  logic [7:0]  e_row;
  logic [PixAddrW-1:0] addr;

  assign total = 16'(cfg_i.block_width) * 16'(cfg_i.block_height);

  always_comb begin
    phase_d = phase_q;
    lit_d   = lit_q;
    pos_d   = pos_q;
    cons_d  = cons_q;
    emit    = 1'b0;
    e_col   = '0;
    e_row   = '0;
    if (restart_i) begin
      phase_d = PhTag;
      lit_d   = '0;
      pos_d   = '0;
      cons_d  = '0;
    end
    if (!(pos_d.fin || cons_d >= total)) begin
      if (!cfg_i.rle_mode) begin
        pos_d = row_end(pos_d, cfg_i.block_width, cfg_i.block_height);
        if (!pos_d.fin) begin
          cons_d    = cons_d + 16'd1;
          emit      = 1'b1;
          e_col     = pos_d.col;
          e_row     = pos_d.row;
          pos_d.col = pos_d.col + 10'd1;
          pos_d     = row_end(pos_d, cfg_i.block_width, cfg_i.block_height);
        end
      end else begin
        case (phase_d)
          PhTag: begin
            pos_d = row_end(pos_d, cfg_i.block_width, cfg_i.block_height);
            if (!pos_d.fin) begin
              phase_d = (byte_i == 8'd0) ? PhSkip : PhCount;
              cons_d  = cons_d + 16'd1;
            end
          end
          PhSkip: begin
            pos_d.col = pos_d.col + 10'(byte_i);
            phase_d   = PhTag;
            cons_d    = cons_d + 16'd1;
          end
          PhCount: begin
            lit_d   = byte_i;
            phase_d = (byte_i == 8'd0) ? PhTag : PhLit;
            cons_d  = cons_d + 16'd1;
          end
          default: begin
            emit      = 1'b1;
            e_col     = pos_d.col;
            e_row     = pos_d.row;
            pos_d.col = pos_d.col + 10'd1;
            lit_d     = lit_d - 8'd1;
            if (lit_d == 8'd0) phase_d = PhTag;
            cons_d    = cons_d + 16'd1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhTag;
      lit_q   <= '0;
      pos_q   <= '0;
      cons_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      pos_q   <= pos_d;
      cons_q  <= cons_d;
    end
  end

  rsbd_addr u_addr (
    .cfg_i  (cfg_i),
    .col_i  (e_col),
    .row_i  (e_row),
    .addr_o (addr)
  );

  assign res_o.emit  = emit;
  assign res_o.addr  = addr;
  assign res_o.value = byte_i;

endmodule

`default_nettype wire

### hw/rtl/rle_sprite_blit_decoder_unit.sv
`default_nettype none

// Decodes a sprite's stored bytes, one word per cycle, into framebuffer pixel writes.
// An accepted word lands in an input register; once the result register is free or
// draining, the decode step (phase update, row-end check, one 11x11 pitch multiply and
// address add) runs and any pixel write goes to the result register, and a new word
// is taken every cycle while the result side keeps up. Set restart_i on the first
// word of each sprite. Registers are written through the configuration channel,
// which is always ready; write them only while no word is in flight.
module rle_sprite_blit_decoder_unit import rsbd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          stored_byte_i,
  input  logic                restart_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PixAddrW-1:0] pixel_address_o,
  output logic [7:0]          pixel_value_o
);

  rsbd_cfg_t cfg;
  rsbd_res_t res;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_restart_q;
  logic       out_vld_q, out_vld_d;
  logic [PixAddrW-1:0] out_addr_q;
  logic [7:0] out_value_q;
  logic       fire, accept;

  assign cfg_ready_o = 1'b1;

  rsbd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_valid_i),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  rsbd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .fire_i    (fire),
    .byte_i    (in_byte_q),
    .restart_i (in_restart_q),
    .res_o     (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) in_vld_d = 1'b1;
    else if (fire) in_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (fire) out_vld_d = res.emit;
    else if (!out_stall_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q    <= stored_byte_i;
      in_restart_q <= restart_i;
    end
    if (fire && res.emit) begin
      out_addr_q  <= res.addr;
      out_value_q <= res.value;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign pixel_address_o = out_addr_q;
  assign pixel_value_o   = out_value_q;

endmodule

`default_nettype wire

### hw/rtl/rsbd_checker.sv
`default_nettype none

`include "rle_sprite_blit_decoder_unit_defines.svh"

module rsbd_checker import rsbd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [PixAddrW-1:0] pixel_address_o,
  input logic [7:0]          pixel_value_o
);

  `RSBD_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable({pixel_address_o, pixel_value_o}),
    "stalled pixel write changed")
  `RSBD_ASSERT_RST(a_rst_idle, !rst_ni |=> !out_valid_o && !in_stall_o, "activity during reset")
  `RSBD_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i,
    "input stalled without full result register")
  `RSBD_ASSERT(a_cfg_ready, cfg_valid_i |-> cfg_ready_o, "configuration write refused")

endmodule

bind rle_sprite_blit_decoder_unit rsbd_checker u_rsbd_checker (.*);

`default_nettype wire

### bench/tb_rle_sprite_blit_decoder_unit.sv
`timescale 1ns / 100ps

module tb_rle_sprite_blit_decoder_unit;
  import rsbd_pkg::*;

  localparam int unsigned CycleLimit = 500000;

  typedef struct packed {
    logic [PixAddrW-1:0] addr;
    logic [7:0]          value;
  } pix_write_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          stored_byte_i = '0;
  logic                restart_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PixAddrW-1:0] pixel_address_o;
  logic [7:0]          pixel_value_o;

  rsbd_cfg_t   cfg_mirror;
  rsbd_phase_e dec_phase;
  logic [7:0]  lits_left;
  logic [9:0]  col_n;
  logic [7:0]  row_n;
  logic [15:0] words_used;
  bit          sprite_done;

  pix_write_t pending_writes[$];
  pix_write_t next_write;

  bit          restart_next = 1'b0;
  bit          idle_en = 1'b1;
  int          hold_cycles = 0;
  int          stall_left = 0;
  int          errors = 0;
  int          sent_words = 0;
  int unsigned cycle_count = 0;

  rle_sprite_blit_decoder_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stored_byte_i  (stored_byte_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_address_o(pixel_address_o),
    .pixel_value_o  (pixel_value_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void clear_sprite();
    dec_phase   = PhTag;
    lits_left   = '0;
    col_n       = '0;
    row_n       = '0;
    words_used  = '0;
    sprite_done = 1'b0;
  endfunction

  function automatic bit sprite_over();
    int unsigned area;
    area = cfg_mirror.block_width * cfg_mirror.block_height;
    return sprite_done || (words_used >= area);
  endfunction

  function automatic void close_row();
    if (col_n >= cfg_mirror.block_width) begin
      col_n = '0;
      row_n = row_n + 8'd1;
      if (row_n >= cfg_mirror.block_height || row_n == 8'd0) sprite_done = 1'b1;
    end
    if (row_n >= cfg_mirror.block_height) sprite_done = 1'b1;
  endfunction

  function automatic void queue_pixel(input logic [7:0] v);
    int unsigned a;
    pix_write_t w;
    a = cfg_mirror.pos_x + col_n + cfg_mirror.screen_width * (cfg_mirror.pos_y + row_n);
    w.addr  = a[PixAddrW-1:0];
    w.value = v;
    pending_writes.push_back(w);
  endfunction

  function automatic void decode_word(input logic [7:0] b, input logic rs);
    if (rs) clear_sprite();
    if (sprite_over()) return;
    if (!cfg_mirror.rle_mode) begin
      close_row();
      if (sprite_done) return;
      words_used = words_used + 16'd1;
      queue_pixel(b);
      col_n = col_n + 10'd1;
      close_row();
      return;
    end
    case (dec_phase)
      PhTag: begin
        close_row();
        if (sprite_done) return;
        dec_phase = (b == 8'h00) ? PhSkip : PhCount;
      end
      PhSkip: begin
        col_n     = col_n + 10'(b);
        dec_phase = PhTag;
      end
      PhCount: begin
        lits_left = b;
        dec_phase = (b == 8'h00) ? PhTag : PhLit;
      end
      default: begin
        queue_pixel(b);
        col_n     = col_n + 10'd1;
        lits_left = lits_left - 8'd1;
        if (lits_left == 8'd0) dec_phase = PhTag;
      end
    endcase
    words_used = words_used + 16'd1;
  endfunction

  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = (idle_en && $urandom_range(0, 1)) ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stored_byte_i <= b;
    restart_i     <= restart_next;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_word(b, restart_next);
    restart_next = 1'b0;
    sent_words++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input rsbd_reg_e idx, input int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CfgDataW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegRleMode:     cfg_mirror.rle_mode     = val[0];
      RegBlockWidth:  cfg_mirror.block_width  = val[7:0];
      RegBlockHeight: cfg_mirror.block_height = val[7:0];
      RegScreenWidth: cfg_mirror.screen_width = val[10:0];
      RegPosX:        cfg_mirror.pos_x        = val[9:0];
      RegPosY:        cfg_mirror.pos_y        = val[9:0];
      default: ;
    endcase
  endtask

  task automatic program_block(input int unsigned mode, input int unsigned w,
                               input int unsigned h, input int unsigned pitch,
                               input int unsigned x, input int unsigned y);
    write_reg(RegRleMode, mode);
    write_reg(RegBlockWidth, w);
    write_reg(RegBlockHeight, h);
    write_reg(RegScreenWidth, pitch);
    write_reg(RegPosX, x);
    write_reg(RegPosY, y);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_token_basics();
    restart_next = 1'b1;
    send_word(8'h07); send_word(8'd3);
    send_word(8'h00); send_word(8'hFF); send_word(8'h5A);
    send_word(8'h00); send_word(8'd0);
    send_word(8'h01); send_word(8'd0);
    send_word(8'h00); send_word(8'd10);
    send_word(8'hFF); send_word(8'd1); send_word(8'h81);
    settle();
  endtask

  task automatic test_raw_wrap();
    program_block(0, 3, 2, 1024, 1023, 1023);
    restart_next = 1'b1;
    send_word(8'hA5); send_word(8'h3C); send_word(8'hFF);
    send_word(8'h00); send_word(8'h01); send_word(8'h80);
    send_word(8'h77);
    restart_next = 1'b1;
    send_word(8'h42);
    settle();
  endtask

  task automatic test_literal_overrun();
    program_block(1, 2, 3, 7, 5, 2);
    restart_next = 1'b1;
    send_word(8'h11); send_word(8'd5);
    repeat (5) send_word(8'($urandom_range(0, 255)));
    send_word(8'h22); send_word(8'd1); send_word(8'h99);
    settle();
  endtask

  task automatic test_sprite_limits();
    program_block(1, 8, 1, 100, 0, 0);
    restart_next = 1'b1;
    send_word(8'h00); send_word(8'd8);
    send_word(8'h01); send_word(8'h05);
    settle();
    program_block(1, 2, 2, 100, 3, 3);
    restart_next = 1'b1;
    send_word(8'h03); send_word(8'd4);
    send_word(8'hAA); send_word(8'hBB); send_word(8'hCC); send_word(8'hDD);
    settle();
    program_block(1, 0, 5, 100, 0, 0);
    restart_next = 1'b1;
    send_word(8'h01); send_word(8'd1); send_word(8'h10);
    settle();
    program_block(0, 4, 0, 100, 0, 0);
    restart_next = 1'b1;
    send_word(8'h20); send_word(8'h21);
    settle();
  endtask

  task automatic test_config_midsprite();
    program_block(1, 8, 4, 64, 10, 3);
    restart_next = 1'b1;
    send_word(8'h01); send_word(8'd6);
    repeat (6) send_word(8'($urandom_range(0, 255)));
    settle();
    program_block(1, 4, 4, 64, 10, 3);
    send_word(8'h02); send_word(8'd2); send_word(8'hE1); send_word(8'hE2);
    send_word(8'h03);
    settle();
    program_block(0, 4, 4, 64, 10, 3);
    send_word(8'hB1); send_word(8'hB2); send_word(8'hB3);
    settle();
    program_block(1, 4, 4, 64, 10, 3);
    send_word(8'd2); send_word(8'hC1); send_word(8'hC2);
    settle();
  endtask

  task automatic test_backpressure();
    program_block(1, 255, 255, 1024, 1, 1);
    idle_en = 1'b0;
    restart_next = 1'b1;
    send_word(8'h01); send_word(8'd200);
    hold_cycles = 80;
    repeat (200) send_word(8'($urandom_range(0, 255)));
    settle();
    idle_en = 1'b1;
  endtask

  task automatic gen_sprite(input int cap);
    int n;
    int kind;
    int cnt;
    n = 0;
    restart_next = 1'b1;
    while (n < cap && (restart_next || !sprite_over())) begin
      if (!cfg_mirror.rle_mode) begin
        send_word(8'($urandom_range(0, 255)));
        n++;
      end else begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          if ($urandom_range(0, 15) == 0) restart_next = 1'b1;
          send_word(8'($urandom_range(0, 255)));
          n++;
        end else if (kind < 5) begin
          cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(0, cfg_mirror.block_width);
          send_word(8'h00);
          send_word(8'(cnt));
          n += 2;
        end else begin
          cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
          send_word(8'($urandom_range(1, 255)));
          send_word(8'(cnt));
          repeat (cnt) send_word(8'($urandom_range(0, 255)));
          n += cnt + 2;
        end
      end
    end
  endtask

  task automatic test_random_sprites();
    int start;
    int unsigned w;
    int unsigned h;
    for (int p = 0; p < 8; p++) begin
      settle();
      if (p == 0) begin
        program_block(0, 1, 1, 1, 0, 0);
      end else if (p == 1) begin
        program_block(1, 255, 255, 1024, 1023, 1023);
      end else begin
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 20);
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 10);
        program_block((($urandom_range(0, 3) != 0) ? 1 : 0), w, h, $urandom_range(1, 1024),
                      $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      idle_en = (p % 4 != 3);
      start = sent_words;
      while (sent_words - start < 72) gen_sprite(72 - (sent_words - start));
    end
    idle_en = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) stall_left = idle_en ? $urandom_range(0, 14) : 0;
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_writes.size() == 0) begin
        $error("pixel write with none pending: pixel_address %0h pixel_value %0h",
               pixel_address_o, pixel_value_o);
        errors++;
      end else begin
        next_write = pending_writes.pop_front();
        if (pixel_address_o !== next_write.addr) begin
          $error("pixel_address expected %0h got %0h", next_write.addr, pixel_address_o);
          errors++;
        end
        if (pixel_value_o !== next_write.value) begin
          $error("pixel_value expected %0h got %0h", next_write.value, pixel_value_o);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    cfg_mirror.rle_mode     = 1'b1;
    cfg_mirror.block_width  = 8'd16;
    cfg_mirror.block_height = 8'd16;
    cfg_mirror.screen_width = 11'd320;
    cfg_mirror.pos_x        = '0;
    cfg_mirror.pos_y        = '0;
    clear_sprite();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_token_basics();
    test_raw_wrap();
    test_literal_overrun();
    test_sprite_limits();
    test_config_midsprite();
    test_backpressure();
    test_random_sprites();
    settle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
